### hw/rtl/es2utc_pkg.sv
// Shared widths, calendar constants and types for the epoch-seconds to UTC date pipeline.
// No dependencies; used by es2utc_tod, es2utc_civil and the top level.
package es2utc_pkg;

  // Result field widths
  localparam int YEAR_W  = 12;
  localparam int MONTH_W = 4;
  localparam int MDAY_W  = 5;
  localparam int HOUR_W  = 5;
  localparam int MIN_W   = 6;
  localparam int SEC_W   = 6;
  localparam int WDAY_W  = 3;
  localparam int YDAY_W  = 9;

  // Internal widths
  localparam int DAY_REM_W = 17;  // seconds within a day, below 86400
  localparam int DOE_W     = 18;  // day of a 400-year era, below 146097
  localparam int YOE_W     = 9;   // year of era, 0..399
  localparam int DOY_W     = 9;   // day of March-based year, 0..365
  localparam int MP_W      = 4;   // March-based month, 0..11

  // 86400 = 675 << 7
  localparam int DAY_SHIFT   = 7;
  localparam int DAY_DIV_ODD = 675;
  localparam int MIN_DIV_ODD_W = 10;

  localparam int SECS_PER_MIN  = 60;
  localparam int MINS_PER_HOUR = 60;
  localparam int DAYS_PER_WEEK = 7;
  localparam int DAYS_PER_ERA  = 146097;
  localparam int DAYS_4Y_CYC   = 1460;
  localparam int DAYS_100Y_CYC = 36524;
  localparam int DAYS_ERA_LAST = 146096;
  localparam int DAYS_PER_YEAR = 365;
  localparam int YEARS_PER_CENT = 100;

  localparam int                SHIFT_W     = 20;
  localparam logic [SHIFT_W-1:0] EPOCH_SHIFT = 20'd719468;  // 0000-03-01 to 1970-01-01
  localparam logic [2:0]        WDAY_OFFSET = 3'd4;         // 1970-01-01 was a Thursday

  localparam logic [MP_W-1:0]   MP_JAN      = 4'd10;        // January in March-based months
  localparam logic [MP_W-1:0]   MP_TO_MON   = 4'd2;
  localparam logic [DOY_W-1:0]  DOY_JAN1    = 9'd306;
  localparam logic [DOY_W-1:0]  YDAY_MAR1   = 9'd59;        // before the leap day
  localparam logic [YEAR_W-1:0] YEARS_ERA   = 12'd400;
  localparam logic [YEAR_W-1:0] YEAR_BASE   = 12'd1900;

  // First day of each March-based month within the March-based year
  localparam logic [DOY_W-1:0] MONTH_START [12] = '{
    9'd0,   9'd31,  9'd61,  9'd92,  9'd122, 9'd153,
    9'd184, 9'd214, 9'd245, 9'd275, 9'd306, 9'd337
  };

  typedef struct packed {
    logic [HOUR_W-1:0] hour;
    logic [MIN_W-1:0]  minute;
    logic [SEC_W-1:0]  second;
  } tod_t;

endpackage

### hw/rtl/es2utc_divc.sv
// Two-stage divider by a constant: reciprocal multiply, then quotient and remainder.
// Standalone; exact for every N-bit dividend.
module es2utc_divc #(
  parameter int N  = 18,
  parameter int D  = 365,
  parameter int QW = 9,
  parameter int RW = $clog2(D)
) (
  input  logic          clk,
  input  logic          en,
  input  logic [N-1:0]  x_i,
  output logic [QW-1:0] q_o,
  output logic [RW-1:0] r_o
);

  // M = ceil(2^S / D); the extra shift bit keeps the rounding error below one
  localparam int          S   = N + RW + 1;
  localparam int          MW  = S - RW + 2;
  localparam int          PW  = N + MW;
  localparam logic [63:0] M64 = ((64'd1 << S) + 64'(D) - 64'd1) / 64'(D);
  localparam logic [MW-1:0] M = M64[MW-1:0];
  localparam logic [N-1:0]  DN = N'(D);

  logic [PW-1:0]     prod_r;
  logic [N-1:0]      x_r;
  logic [QW-1:0]     q_r;
  logic [RW-1:0]     r_r;
  logic [N-RW+1:0]   qfull;
  logic [N-1:0]      qd;
  logic [N-1:0]      rfull;

  assign qfull = prod_r[PW-1:S];
  assign qd    = N'(qfull) * DN;
  assign rfull = x_r - qd;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= PW'(x_i) * PW'(M);
      x_r    <= x_i;
      q_r    <= qfull[QW-1:0];
      r_r    <= rfull[RW-1:0];
    end
  end

  assign q_o = q_r;
  assign r_o = r_r;

endmodule

### hw/rtl/es2utc_dly.sv
// Enable-gated delay line of N register stages for side data in the pipeline.
// Standalone.
module es2utc_dly #(
  parameter int W = 8,
  parameter int N = 2
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] pipe_r [N];

  always_ff @(posedge clk) begin
    if (en) begin
      pipe_r[0] <= d_i;
      for (int i = 1; i < N; i++) begin
        pipe_r[i] <= pipe_r[i-1];
      end
    end
  end

  assign q_o = pipe_r[N-1];

endmodule

### hw/rtl/es2utc_tod.sv
// Time of day from seconds within a day: four stages, two chained divides by 60.
// Depends on es2utc_pkg, es2utc_divc, es2utc_dly.
module es2utc_tod (
  input  logic                             clk,
  input  logic                             en,
  input  logic [es2utc_pkg::DAY_REM_W-1:0] rem_i,
  output es2utc_pkg::tod_t                 tod_o
);

  localparam int QM_W = 11;  // minutes of the day, below 1440

  logic [QM_W-1:0]                 mins_w;
  logic [es2utc_pkg::SEC_W-1:0]    sec_w;
  logic [es2utc_pkg::SEC_W-1:0]    sec_d;
  logic [es2utc_pkg::HOUR_W-1:0]   hour_w;
  logic [es2utc_pkg::MIN_W-1:0]    min_w;

  es2utc_divc #(
    .N (es2utc_pkg::DAY_REM_W), .D (es2utc_pkg::SECS_PER_MIN), .QW (QM_W)
  ) u_div_sec (
    .clk (clk), .en (en), .x_i (rem_i), .q_o (mins_w), .r_o (sec_w)
  );

  es2utc_divc #(
    .N (QM_W), .D (es2utc_pkg::MINS_PER_HOUR), .QW (es2utc_pkg::HOUR_W)
  ) u_div_min (
    .clk (clk), .en (en), .x_i (mins_w), .q_o (hour_w), .r_o (min_w)
  );

  es2utc_dly #(.W (es2utc_pkg::SEC_W), .N (2)) u_dly_sec (
    .clk (clk), .en (en), .d_i (sec_w), .q_o (sec_d)
  );

  assign tod_o.hour   = hour_w;
  assign tod_o.minute = min_w;
  assign tod_o.second = sec_d;

endmodule

### hw/rtl/es2utc_civil.sv
// Civil date from a day count: era split, year of era, month search, weekday. 13 stages.
// Depends on es2utc_pkg, es2utc_divc, es2utc_dly.
module es2utc_civil #(
  parameter int DW = 20
) (
  input  logic                           clk,
  input  logic                           en,
  input  logic [DW-1:0]                  days_i,
  output logic [es2utc_pkg::YEAR_W-1:0]  year_o,
  output logic [es2utc_pkg::MONTH_W-1:0] month_o,
  output logic [es2utc_pkg::MDAY_W-1:0]  mday_o,
  output logic [es2utc_pkg::WDAY_W-1:0]  wday_o,
  output logic [es2utc_pkg::YDAY_W-1:0]  yday_o
);

  localparam int ZW = ((DW > es2utc_pkg::SHIFT_W) ? DW : es2utc_pkg::SHIFT_W) + 1;
  localparam int EW = ZW - 16;
  localparam int XW = DW + 1;
  localparam int DOE_W = es2utc_pkg::DOE_W;
  localparam int YOE_W = es2utc_pkg::YOE_W;
  localparam int DOY_W = es2utc_pkg::DOY_W;
  localparam int MP_W  = es2utc_pkg::MP_W;
  localparam int YW    = es2utc_pkg::YEAR_W;

  // stage 1
  logic [ZW-1:0]    z_r;
  logic [XW-1:0]    wdx_r;
  // stages 2-3
  logic [EW-1:0]    era_w;
  logic [DOE_W-1:0] doe_w;
  logic [2:0]       wday_w;
  // stages 4-5
  logic [6:0]       c4y_w;
  logic [2:0]       c100y_w;
  logic [0:0]       cera_w;
  logic [DOE_W-1:0] doe_d2;
  logic [DOE_W-1:0] doe_d7;
  // stage 6
  logic [DOE_W-1:0] t_r;
  // stages 7-8
  logic [YOE_W-1:0] yoe_w;
  // stages 9-10
  logic [1:0]       cent_w;
  logic [DOE_W-1:0] p_r;
  logic [DOE_W-1:0] p2_r;
  // stage 11
  logic [DOE_W-1:0] doy_full;
  logic [DOY_W-1:0] doy_r;
  logic [YOE_W-1:0] yoe_d3;
  logic [YW-1:0]    era400_w;
  logic [YW-1:0]    era400_d8;
  // stage 12
  logic [MP_W-1:0]  mp_nxt;
  logic [MP_W-1:0]  mp_r;
  logic [DOY_W-1:0] doy2_r;
  logic             leap_nxt;
  logic             leap_r;
  logic [YW-1:0]    ybase_r;
  // stage 13
  logic             jan_feb;
  logic [DOY_W-1:0] mday_full;
  logic [YW-1:0]                  year_r;
  logic [es2utc_pkg::MONTH_W-1:0] month_r;
  logic [es2utc_pkg::MDAY_W-1:0]  mday_r;
  logic [es2utc_pkg::YDAY_W-1:0]  yday_r;

  always_ff @(posedge clk) begin
    if (en) begin
      z_r   <= ZW'(days_i) + ZW'(es2utc_pkg::EPOCH_SHIFT);
      wdx_r <= XW'(days_i) + XW'(es2utc_pkg::WDAY_OFFSET);
    end
  end

  es2utc_divc #(.N (ZW), .D (es2utc_pkg::DAYS_PER_ERA), .QW (EW)) u_div_era (
    .clk (clk), .en (en), .x_i (z_r), .q_o (era_w), .r_o (doe_w)
  );

  es2utc_divc #(.N (XW), .D (es2utc_pkg::DAYS_PER_WEEK), .QW (1)) u_div_wday (
    .clk (clk), .en (en), .x_i (wdx_r), .q_o (), .r_o (wday_w)
  );

  // Leap-cycle corrections of the day of era
  es2utc_divc #(.N (DOE_W), .D (es2utc_pkg::DAYS_4Y_CYC), .QW (7)) u_div_4y (
    .clk (clk), .en (en), .x_i (doe_w), .q_o (c4y_w), .r_o ()
  );

  es2utc_divc #(.N (DOE_W), .D (es2utc_pkg::DAYS_100Y_CYC), .QW (3)) u_div_100y (
    .clk (clk), .en (en), .x_i (doe_w), .q_o (c100y_w), .r_o ()
  );

  es2utc_divc #(.N (DOE_W), .D (es2utc_pkg::DAYS_ERA_LAST), .QW (1)) u_div_erae (
    .clk (clk), .en (en), .x_i (doe_w), .q_o (cera_w), .r_o ()
  );

  es2utc_dly #(.W (DOE_W), .N (2)) u_dly_doe2 (
    .clk (clk), .en (en), .d_i (doe_w), .q_o (doe_d2)
  );

  es2utc_dly #(.W (DOE_W), .N (5)) u_dly_doe7 (
    .clk (clk), .en (en), .d_i (doe_d2), .q_o (doe_d7)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      t_r <= doe_d2 - DOE_W'(c4y_w) + DOE_W'(c100y_w) - DOE_W'(cera_w);
    end
  end

  es2utc_divc #(.N (DOE_W), .D (es2utc_pkg::DAYS_PER_YEAR), .QW (YOE_W)) u_div_yoe (
    .clk (clk), .en (en), .x_i (t_r), .q_o (yoe_w), .r_o ()
  );

  es2utc_divc #(.N (YOE_W), .D (es2utc_pkg::YEARS_PER_CENT), .QW (2)) u_div_cent (
    .clk (clk), .en (en), .x_i (yoe_w), .q_o (cent_w), .r_o ()
  );

  es2utc_dly #(.W (YOE_W), .N (3)) u_dly_yoe (
    .clk (clk), .en (en), .d_i (yoe_w), .q_o (yoe_d3)
  );

  assign era400_w = YW'(era_w) * es2utc_pkg::YEARS_ERA;

  es2utc_dly #(.W (YW), .N (8)) u_dly_era (
    .clk (clk), .en (en), .d_i (era400_w), .q_o (era400_d8)
  );

  es2utc_dly #(.W (es2utc_pkg::WDAY_W), .N (10)) u_dly_wday (
    .clk (clk), .en (en), .d_i (wday_w), .q_o (wday_o)
  );

  assign doy_full = doe_d7 - p2_r + DOE_W'(cent_w);

  always_comb begin
    mp_nxt = '0;
    for (int i = 1; i < 12; i++) begin
      if (doy_r >= es2utc_pkg::MONTH_START[i]) begin
        mp_nxt = MP_W'(i);
      end
    end
    // leap test needs only the year of era: the era contributes a multiple of 400
    leap_nxt = (yoe_d3[1:0] == 2'd0) && !(yoe_d3 inside {9'd100, 9'd200, 9'd300});
  end

  assign jan_feb   = (mp_r >= es2utc_pkg::MP_JAN);
  assign mday_full = doy2_r - es2utc_pkg::MONTH_START[mp_r] + 9'd1;

  always_ff @(posedge clk) begin
    if (en) begin
      p_r     <= DOE_W'(yoe_w) * DOE_W'(es2utc_pkg::DAYS_PER_YEAR) + DOE_W'(yoe_w[YOE_W-1:2]);
      p2_r    <= p_r;
      doy_r   <= doy_full[DOY_W-1:0];
      mp_r    <= mp_nxt;
      doy2_r  <= doy_r;
      leap_r  <= leap_nxt;
      ybase_r <= era400_d8 + YW'(yoe_d3);
      year_r  <= ybase_r + YW'(jan_feb) - es2utc_pkg::YEAR_BASE;
      month_r <= jan_feb ? (mp_r - es2utc_pkg::MP_JAN) : (mp_r + es2utc_pkg::MP_TO_MON);
      mday_r  <= mday_full[es2utc_pkg::MDAY_W-1:0];
      yday_r  <= jan_feb ? (doy2_r - es2utc_pkg::DOY_JAN1)
                         : (doy2_r + es2utc_pkg::YDAY_MAR1 + DOY_W'(leap_r));
    end
  end

  assign year_o  = year_r;
  assign month_o = month_r;
  assign mday_o  = mday_r;
  assign yday_o  = yday_r;

endmodule

### hw/rtl/epoch_seconds_to_utc_date.sv
// Top level: converts seconds since 1970-01-01 UTC into a broken-down UTC date and time.
// Depends on es2utc_pkg, es2utc_divc, es2utc_dly, es2utc_tod, es2utc_civil.
//
// Usage:
//   Input channel in_valid/in_ready carries in_epoch_seconds (SECONDS_WIDTH bits).
//   Result channel out_valid/out_ready carries year, month, day of month, hour,
//   minute, second, weekday and day of year for each input, in input order.
//   Throughput is one conversion per cycle while out_ready keeps the pipeline
//   moving: a 16-stage pipeline with one valid bit per stage, in which no path
//   through a stage passes more than one constant-divide multiply.
//   The longest paths are the reciprocal multiplies of the divide by 675 (day
//   split) and by 146097 (400-year era split).
//   When out_valid is high and out_ready low, the whole pipeline holds and
//   in_ready drops; nothing is dropped or repeated. Empty stages hold too.
//   Synchronous reset (rst_n low) clears all valid bits; data registers keep
//   whatever they held and are ignored until refilled.
module epoch_seconds_to_utc_date #(
  parameter int SECONDS_WIDTH = 36
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [SECONDS_WIDTH-1:0]         in_epoch_seconds,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [es2utc_pkg::YEAR_W-1:0]    out_years_since_1900,
  output logic [es2utc_pkg::MONTH_W-1:0]   out_month_index,
  output logic [es2utc_pkg::MDAY_W-1:0]    out_day_of_month,
  output logic [es2utc_pkg::HOUR_W-1:0]    out_hour_of_day,
  output logic [es2utc_pkg::MIN_W-1:0]     out_minute_of_hour,
  output logic [es2utc_pkg::SEC_W-1:0]     out_second_of_minute,
  output logic [es2utc_pkg::WDAY_W-1:0]    out_weekday,
  output logic [es2utc_pkg::YDAY_W-1:0]    out_day_of_year
);

  localparam int DW     = SECONDS_WIDTH - 16;  // day count width
  localparam int XW     = SECONDS_WIDTH - es2utc_pkg::DAY_SHIFT;
  localparam int SH     = es2utc_pkg::DAY_SHIFT;
  localparam int STAGES = 16;

  logic                               en;
  logic [STAGES-1:0]                  vld_r;
  logic [STAGES-1:0]                  vld_nxt;
  logic [SECONDS_WIDTH-1:0]           secs_r;
  logic [DW-1:0]                      days_w;
  logic [es2utc_pkg::MIN_DIV_ODD_W-1:0] r675_w;
  logic [SH-1:0]                      low_d;
  logic [es2utc_pkg::DAY_REM_W-1:0]   rem_w;
  es2utc_pkg::tod_t                   tod_w;
  es2utc_pkg::tod_t                   tod_d;

  // Advance everything unless a finished result is waiting
  assign en        = out_ready || !vld_r[STAGES-1];
  assign in_ready  = en;
  assign out_valid = vld_r[STAGES-1];
  assign vld_nxt   = {vld_r[STAGES-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      secs_r <= in_epoch_seconds;
    end
  end

  // Day split: secs / 86400 as (secs >> 7) / 675, low bits rejoin the remainder
  es2utc_divc #(.N (XW), .D (es2utc_pkg::DAY_DIV_ODD), .QW (DW)) u_div_day (
    .clk (clk), .en (en), .x_i (secs_r[SECONDS_WIDTH-1:SH]), .q_o (days_w), .r_o (r675_w)
  );

  es2utc_dly #(.W (SH), .N (2)) u_dly_low (
    .clk (clk), .en (en), .d_i (secs_r[SH-1:0]), .q_o (low_d)
  );

  assign rem_w = {r675_w, low_d};

  es2utc_tod u_tod (
    .clk (clk), .en (en), .rem_i (rem_w), .tod_o (tod_w)
  );

  // Line up time of day with the longer date path
  es2utc_dly #(.W ($bits(es2utc_pkg::tod_t)), .N (9)) u_dly_tod (
    .clk (clk), .en (en), .d_i (tod_w), .q_o (tod_d)
  );

  es2utc_civil #(.DW (DW)) u_civil (
    .clk     (clk),
    .en      (en),
    .days_i  (days_w),
    .year_o  (out_years_since_1900),
    .month_o (out_month_index),
    .mday_o  (out_day_of_month),
    .wday_o  (out_weekday),
    .yday_o  (out_day_of_year)
  );

  assign out_hour_of_day      = tod_d.hour;
  assign out_minute_of_hour   = tod_d.minute;
  assign out_second_of_minute = tod_d.second;

endmodule
